// ----- hw/rtl/ple_pkg.sv -----
// Package for the positional list engine.
// Holds the list sizing constants, the request and status codes and the cell control struct.
// No dependencies.
`timescale 1ns / 1ps

package ple_pkg;

    // List capacity, the data and port widths, and the widths that follow from the capacity.
    localparam int CAPACITY = 16;
    localparam int DATA_W   = 32;
    localparam int POS_W    = 5;
    localparam int OUT_CNT_W = 5;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    // Width used for position compares against cell indexes and the entry count.
    localparam int CMP_IDX_W = (POS_W > IDX_W) ? POS_W : IDX_W;
    localparam int CMP_CNT_W = (POS_W > CNT_W) ? POS_W : CNT_W;

    // Request codes.
    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_READ   = 2'd1,
        ACT_UPDATE = 2'd2,
        ACT_REMOVE = 2'd3
    } action_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Control broadcast to every cell of the row.
    typedef struct packed {
        logic              ins;
        logic              upd;
        logic              rem;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] value;
    } cell_ctrl_t;

endpackage

// ----- hw/rtl/ple_cell.sv -----
// One storage cell of the positional list row.
// Loads the new value, its left neighbor or its right neighbor as the broadcast control asks.
// Depends on ple_pkg.
`timescale 1ns / 1ps

module ple_cell
    import ple_pkg::*;
(
    input  logic              aclk,
    input  logic [IDX_W-1:0]  cell_index,
    input  cell_ctrl_t        ctrl,
    input  logic [DATA_W-1:0] left_data,
    input  logic [DATA_W-1:0] right_data,
    output logic [DATA_W-1:0] q
);

    logic [DATA_W-1:0]    data_reg;
    logic [DATA_W-1:0]    data_next;
    logic [CMP_IDX_W-1:0] idx_ext;
    logic [CMP_IDX_W-1:0] pos_ext;

    assign idx_ext = CMP_IDX_W'(cell_index);
    assign pos_ext = CMP_IDX_W'(ctrl.pos);

    // An insert shifts cells above the position up, a remove shifts cells at and above it down.
    always_comb begin
        data_next = data_reg;
        if (ctrl.ins) begin
            if (idx_ext == pos_ext) begin
                data_next = ctrl.value;
            end else if (idx_ext > pos_ext) begin
                data_next = left_data;
            end
        end else if (ctrl.upd) begin
            if (idx_ext == pos_ext) begin
                data_next = ctrl.value;
            end
        end else if (ctrl.rem) begin
            if (idx_ext >= pos_ext) begin
                data_next = right_data;
            end
        end
    end

    // Payload storage needs no reset.
    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign q = data_reg;

endmodule

// ----- hw/rtl/ple_chain.sv -----
// Row of list cells with neighbor links and the read select.
// Each cell can take data from its neighbors under one broadcast control word.
// Depends on ple_pkg and ple_cell.
`timescale 1ns / 1ps

module ple_chain
    import ple_pkg::*;
(
    input  logic              aclk,
    input  cell_ctrl_t        ctrl,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] q [CAPACITY];
    logic [IDX_W-1:0]  rd_index;

    // Build the row; the end cells link to the request value and to themselves.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [DATA_W-1:0] left_data;
        logic [DATA_W-1:0] right_data;

        if (i == 0) begin : g_first
            assign left_data = ctrl.value;
        end else begin : g_mid_left
            assign left_data = q[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign right_data = q[i];
        end else begin : g_mid_right
            assign right_data = q[i+1];
        end

        ple_cell u_cell (
            .aclk       (aclk),
            .cell_index (IDX_W'(i)),
            .ctrl       (ctrl),
            .left_data  (left_data),
            .right_data (right_data),
            .q          (q[i])
        );
    end

    // The addressed cell, used only when the position is below the entry count.
    assign rd_index = IDX_W'(ctrl.pos);
    assign rd_data  = q[rd_index];

endmodule

// ----- hw/rtl/positional_list_engine.sv -----
// Positional list engine: an ordered list of signed 32-bit values in a row of shifting cells.
// The result of an accepted request is registered and shown in the next cycle; one request per cycle is taken
// while the result register is empty or being drained, since every cell shifts in parallel.
// Reset (aresetn, synchronous, active low) empties the list and the result register.
// Cell contents are not reset; only cells below the entry count are ever read.
// Depends on ple_pkg, ple_chain and ple_cell.
`timescale 1ns / 1ps

module positional_list_engine
    import ple_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [1:0]               s_action,
    input  logic [POS_W-1:0]         s_position,
    input  logic signed [DATA_W-1:0] s_value,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [DATA_W-1:0] m_data,
    output logic [OUT_CNT_W-1:0]     m_count,
    output logic                     m_is_empty,
    output logic [1:0]               m_status
);

    logic                 m_valid_reg;
    logic                 m_valid_next;
    logic [DATA_W-1:0]    m_data_reg;
    logic [OUT_CNT_W-1:0] m_count_reg;
    logic                 m_is_empty_reg;
    status_t              m_status_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;

    logic                 s_fire;
    logic [CMP_CNT_W-1:0] pos_ext;
    logic [CMP_CNT_W-1:0] cnt_ext;
    status_t              status;
    logic                 op_ok;
    logic [DATA_W-1:0]    rd_data;
    logic [DATA_W-1:0]    res_data;
    cell_ctrl_t           ctrl;

    // The result register frees up in the cycle it is taken.
    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;

    assign pos_ext = CMP_CNT_W'(s_position);
    assign cnt_ext = CMP_CNT_W'(count_reg);

    // Range and capacity checks; the range check wins over the full check.
    always_comb begin
        status = ST_OK;
        if (s_action == ACT_INSERT) begin
            if (pos_ext > cnt_ext) begin
                status = ST_RANGE;
            end else if (count_reg == CNT_W'(CAPACITY)) begin
                status = ST_FULL;
            end
        end else if (pos_ext >= cnt_ext) begin
            status = ST_RANGE;
        end
    end

    assign op_ok = s_fire && (status == ST_OK);

    // Control word for the cell row.
    always_comb begin
        ctrl.ins   = op_ok && (s_action == ACT_INSERT);
        ctrl.upd   = op_ok && (s_action == ACT_UPDATE);
        ctrl.rem   = op_ok && (s_action == ACT_REMOVE);
        ctrl.pos   = s_position;
        ctrl.value = s_value;
    end

    ple_chain u_chain (
        .aclk    (aclk),
        .ctrl    (ctrl),
        .rd_data (rd_data)
    );

    // Entry count update and the returned value.
    always_comb begin
        count_next = count_reg;
        if (ctrl.ins) begin
            count_next = count_reg + CNT_W'(1);
        end else if (ctrl.rem) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_comb begin
        res_data = '0;
        if ((status == ST_OK) &&
            ((s_action == ACT_READ) || (s_action == ACT_REMOVE))) begin
            res_data = rd_data;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (s_fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            count_reg   <= '0;
        end else begin
            m_valid_reg <= m_valid_next;
            count_reg   <= count_next;
        end
    end

    // Result payload, loaded with each transaction.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            m_data_reg     <= res_data;
            m_count_reg    <= OUT_CNT_W'(count_next);
            m_is_empty_reg <= (count_next == '0);
            m_status_reg   <= status;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_data     = m_data_reg;
    assign m_count    = m_count_reg;
    assign m_is_empty = m_is_empty_reg;
    assign m_status   = m_status_reg;

    // The entry count never exceeds the capacity.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // A successful insert grows the list by exactly one entry.
    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.ins |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("insert did not grow the list");

    // A failed request leaves the count alone and returns zero data.
    a_fail_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && (status != ST_OK)) |=>
            ($stable(count_reg) && (m_data_reg == '0)))
        else $error("failed request changed the list or returned data");

    // A full status is only reported with a full list.
    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_status_reg == ST_FULL)) |->
            (m_count_reg == OUT_CNT_W'(CAPACITY)))
        else $error("full status with a list that is not full");

    // The empty flag agrees with the reported count.
    a_empty_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_is_empty_reg == (m_count_reg == '0)))
        else $error("empty flag disagrees with count");

endmodule
